>>> rtl/upc_pkg.sv
// Shared types, character constants and helper functions for the URL percent codec.
// Used by upc_front, upc_queue, upc_back and url_percent_codec_core; no other dependencies.
`timescale 1ns / 1ps

package upc_pkg;

  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTilde   = 8'h7E;
  localparam logic [7:0] CharDash    = 8'h2D;
  localparam logic [7:0] CharUnder   = 8'h5F;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] HexDigitOff = 8'd48;
  localparam logic [7:0] HexAlphaOff = 8'd55;
  localparam logic [4:0] HexInvalid  = 5'd16;

  // One queued piece of work: a single result, or a byte to be escaped as three results.
  typedef struct packed {
    logic       triple;
    logic [7:0] data;
    logic       err;
    logic       eos;
  } entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v > 4'd9) begin
      r = {4'd0, v} + HexAlphaOff;
    end else begin
      r = {4'd0, v} + HexDigitOff;
    end
    return r;
  endfunction

  // Returns 0..15, or HexInvalid when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r = 5'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      r = 5'(c - 8'h61 + 8'd10);
    end else begin
      r = HexInvalid;
    end
    return r;
  endfunction

  function automatic logic plain_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     CharDash, CharUnder, CharDot, CharTilde};
  endfunction

endpackage

>>> rtl/upc_front.sv
// Front end of the URL percent codec: accepts input bytes, tracks the decode escape
// phase and classifies each byte into a queue entry. Depends on upc_pkg.
`timescale 1ns / 1ps

module upc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            clear_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_data_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            full_i,
  output logic            push_o,
  output upc_pkg::entry_t entry_o
);
  import upc_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHigh = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic       accept;
  logic       emit;
  entry_t     entry;
  logic [4:0] hv;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign hv         = hex_value(in_data_i);

  always_comb begin
    phase_d      = phase_q;
    nib_d        = nib_q;
    emit         = 1'b0;
    entry.triple = 1'b0;
    entry.data   = in_data_i;
    entry.err    = 1'b0;
    entry.eos    = in_last_i;
    if (mode_i) begin
      emit = 1'b1;
      if (plain_char(in_data_i)) begin
        entry.data = in_data_i;
      end else if (in_data_i == CharSpace) begin
        entry.data = CharPlus;
      end else begin
        entry.triple = 1'b1;
      end
    end else begin
      case (phase_q)
        PhHigh: begin
          if (hv[4] || in_last_i) begin
            phase_d    = PhIdle;
            emit       = 1'b1;
            entry.err  = 1'b1;
            entry.data = 8'd0;
          end else begin
            nib_d   = hv[3:0];
            phase_d = PhLow;
          end
        end
        PhLow: begin
          phase_d = PhIdle;
          emit    = 1'b1;
          if (hv[4]) begin
            entry.err  = 1'b1;
            entry.data = 8'd0;
          end else begin
            entry.data = {nib_q, hv[3:0]};
          end
        end
        default: begin
          // Idle, and the unused fourth phase code behaves the same way.
          phase_d = PhIdle;
          if (in_data_i == CharPlus) begin
            emit       = 1'b1;
            entry.data = CharSpace;
          end else if (in_data_i == CharPercent) begin
            if (in_last_i) begin
              emit       = 1'b1;
              entry.err  = 1'b1;
              entry.data = 8'd0;
            end else begin
              phase_d = PhHigh;
            end
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end
  end

  assign push_o  = accept && emit;
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      nib_q   <= 4'd0;
    end else if (clear_i) begin
      phase_q <= PhIdle;
      nib_q   <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

  // Encoding never touches the escape state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i && !clear_i) |=> ($stable(phase_q) && $stable(nib_q)))
    else $error("escape state changed while encoding");

endmodule

>>> rtl/upc_queue.sv
// Short work queue between front and back of the URL percent codec, held in flops.
// Depends on upc_pkg for the entry type.
`timescale 1ns / 1ps

module upc_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upc_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            head_valid_o,
  output upc_pkg::entry_t head_o
);
  import upc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> head_valid_o))
    else $error("queue overflow or underflow");

endmodule

>>> rtl/upc_back.sv
// Back end of the URL percent codec: drains queue entries and sequences them into
// result beats through a registered output stage. Depends on upc_pkg.
`timescale 1ns / 1ps

module upc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  upc_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_data_o,
  output logic            out_err_o,
  output logic            out_last_o,
  output logic            out_done_o
);
  import upc_pkg::*;

  localparam logic [1:0] BeatPct = 2'd0;
  localparam logic [1:0] BeatHi  = 2'd1;
  localparam logic [1:0] BeatLo  = 2'd2;

  logic [1:0] beat_q, beat_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       err_q, err_d, last_q, last_d, done_q, done_d;
  logic       load, final_beat;

  assign load       = head_valid_i && (!valid_q || out_ready_i);
  assign final_beat = !head_i.triple || (beat_q == BeatLo);
  assign pop_o      = load && final_beat;

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q && !out_ready_i;
    data_d  = data_q;
    err_d   = err_q;
    last_d  = last_q;
    done_d  = done_q;
    if (load) begin
      valid_d = 1'b1;
      beat_d  = final_beat ? BeatPct : beat_q + 1'b1;
      err_d   = head_i.err;
      last_d  = final_beat;
      done_d  = final_beat && head_i.eos;
      if (head_i.triple) begin
        case (beat_q)
          BeatPct: data_d = CharPercent;
          BeatHi:  data_d = hex_char(head_i.data[7:4]);
          default: data_d = hex_char(head_i.data[3:0]);
        endcase
      end else begin
        data_d = head_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= BeatPct;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    err_q  <= err_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_err_o   = err_q;
  assign out_last_o  = last_q;
  assign out_done_o  = done_q;

  // A beat sequence in flight belongs to an escape entry still at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BeatPct) |-> (head_valid_i && head_i.triple))
    else $error("escape sequence lost its queue entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && done_q) |-> last_q)
    else $error("string end flagged on a beat that is not the last of its byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q) |-> (data_q == 8'd0))
    else $error("error result carries a nonzero byte");

endmodule

>>> rtl/url_percent_codec_core.sv
// URL percent codec, form-urlencoded style: one byte per cycle in when not stalled, percent
// escapes out (encode) or bytes out of escapes (decode). A user can take in one byte every
// clock as long as the result side keeps up; the back end emits one result per cycle while the
// output is ready, so an escaped byte in encode mode occupies the output for three results, and
// a decode byte that only opens or continues an escape is taken in without any output. The
// output beat sequencer sets the sustained rate; a two-entry queue between front and back lets
// the input keep flowing while a result waits. A byte's first result passes the queue and the
// output register. Writing the mode register clears any pending escape.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
`timescale 1ns / 1ps

module url_percent_codec_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_string
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // last_of_run
  output logic [1:0]  m_axis_tuser,   // [0] error, [1] string_done
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import upc_pkg::*;

  localparam logic RegMode = 1'b0;

  logic   mode_q;
  logic   cfg_we;
  logic   push, pop, full, head_valid;
  entry_t push_entry, head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegMode);
  assign prdata = (paddr[2] == RegMode) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we) begin
      mode_q <= pwdata[0];
    end
  end

  upc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .clear_i    (cfg_we),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  upc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  upc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_err_o    (m_axis_tuser[0]),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser[1])
  );

endmodule
